/* rtl/bpfp_pkg.sv */
`timescale 1ns / 1ps
package bpfp_pkg;

  localparam int WIN = 8;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    CFG_PATTERN        = 3'd0,
    CFG_PATTERN_LENGTH = 3'd1,
    CFG_REPLACEMENT    = 3'd2,
    CFG_REPLACE_LENGTH = 3'd3,
    CFG_REPLACE_OFFSET = 3'd4,
    CFG_EVERY_MATCH    = 3'd5
  } bpfp_cfg_idx_t;

  typedef struct packed {
    logic [63:0] pattern;
    logic [3:0]  pattern_length;
    logic [63:0] replacement;
    logic [3:0]  replace_length;
    logic [3:0]  replace_offset;
    logic        every_match;
  } bpfp_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       found;
  } bpfp_item_t;

endpackage

/* rtl/byte_pattern_find_and_patch.sv */
`timescale 1ns / 1ps
// byte pattern find and patch
// in_*: raw image bytes, one per transaction, in_tlast on the final byte.
// out_*: the same bytes in order after patching; out_tlast on the final
//   byte, out_tuser on that byte is 1 if the pattern was found in the image.
// cfg_*: register writes (pattern, length, replacement, replace length,
//   replace offset, every-match), allowed only while the block is idle.
// a byte position is decided once pattern_length bytes from it are held,
// so a byte leaves after pattern_length - 1 later bytes have arrived, or
// right after the final byte, when the remaining bytes flush one per cycle
// while the queue has room. the decision unit compares the window and
// writes the patch in the cycle the deciding byte enters; the result then
// passes a 4-entry queue and the output register before it shows on out_*.
// throughput is one byte per cycle while the queue has room; after the
// final byte the input waits while the held bytes flush.
// reset clears the window count, the pending patch bytes and the
// registers to their defaults. when out_tready is low the output register
// holds, the queue fills and then in_tready drops; nothing is lost.
module byte_pattern_find_and_patch #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REACH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,
  output logic        out_tuser,  // found
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import bpfp_pkg::*;

  bpfp_cfg_t  cfg_r, cfg_nxt;
  bpfp_item_t push_item, q_item;
  logic       push, full, pop, q_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN:        cfg_nxt.pattern = cfg_wdata;
        CFG_PATTERN_LENGTH: cfg_nxt.pattern_length = cfg_wdata[3:0];
        CFG_REPLACEMENT:    cfg_nxt.replacement = cfg_wdata;
        CFG_REPLACE_LENGTH: cfg_nxt.replace_length = cfg_wdata[3:0];
        CFG_REPLACE_OFFSET: cfg_nxt.replace_offset = cfg_wdata[3:0];
        CFG_EVERY_MATCH:    cfg_nxt.every_match = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern <= 64'd0;
      cfg_r.pattern_length <= 4'd8;
      cfg_r.replacement <= 64'd0;
      cfg_r.replace_length <= 4'd4;
      cfg_r.replace_offset <= 4'd0;
      cfg_r.every_match <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bpfp_front #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_REACH(MAX_REACH)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_byte(in_tdata),
    .in_last(in_tlast),
    .q_full(full),
    .push(push),
    .push_item(push_item)
  );

  bpfp_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_item(push_item),
    .full(full),
    .pop(pop),
    .q_valid(q_valid),
    .q_item(q_item)
  );

  bpfp_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_item(q_item),
    .pop(pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

endmodule

/* rtl/bpfp_front.sv */
`timescale 1ns / 1ps
module bpfp_front #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REACH   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bpfp_pkg::bpfp_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                q_full,
  output logic                push,
  output bpfp_pkg::bpfp_item_t push_item
);
  import bpfp_pkg::*;

  localparam int PEND = MAX_REACH + MAX_PATTERN;
  localparam int PIW = $clog2(PEND);
  localparam int DW = ($clog2(PEND + 1) > 5) ? $clog2(PEND + 1) : 5;
  localparam int CAP = (MAX_PATTERN < WIN) ? MAX_PATTERN : WIN;

  logic [7:0] win_r [WIN];
  logic [7:0] win_nxt [WIN];
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] pv_r [PEND];
  logic [7:0] pv_nxt [PEND];
  logic       pk_r [PEND];
  logic       pk_nxt [PEND];
  logic       seen_r, seen_nxt;
  logic       last_r, last_nxt;

  logic [7:0] w_a [WIN];
  logic [7:0] pv_a [PEND];
  logic       pk_a [PEND];
  logic [3:0] len_eff, rl_eff, cnt_a, cnt_p;
  logic [7:0] b_in;
  logic       busy, accept, step, lastf, do_dec, do_pop, hit, fire, seen_a, fin;
  logic [4:0] p;
  logic [DW-1:0] d;

  always_comb begin
    if (cfg.pattern_length == 4'd0) begin
      len_eff = 4'd1;
    end else if (cfg.pattern_length > 4'(CAP)) begin
      len_eff = 4'(CAP);
    end else begin
      len_eff = cfg.pattern_length;
    end
    rl_eff = (cfg.replace_length > 4'd8) ? 4'd8 : cfg.replace_length;
  end

  assign busy = (cnt_r >= len_eff) || last_r;
  assign in_ready = !busy && !q_full;
  assign accept = in_valid && in_ready;
  assign step = accept || (busy && !q_full);

  always_comb begin
    b_in = pk_r[0] ? pv_r[0] : in_byte;
    w_a = win_r;
    pv_a = pv_r;
    pk_a = pk_r;
    cnt_a = cnt_r;
    if (accept) begin
      w_a[cnt_r[2:0]] = b_in;
      cnt_a = cnt_r + 4'd1;
      for (int i = 0; i < PEND - 1; i++) begin
        pv_a[i] = pv_r[i + 1];
        pk_a[i] = pk_r[i + 1];
      end
      pv_a[PEND - 1] = 8'd0;
      pk_a[PEND - 1] = 1'b0;
    end
    lastf = last_r || (accept && in_last);
    do_dec = cnt_a >= len_eff;
    do_pop = do_dec || (lastf && cnt_a != 4'd0);

    hit = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      if (4'(k) < len_eff && w_a[k] != cfg.pattern[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    fire = step && do_dec && hit && (cfg.every_match || !seen_r);
    seen_a = seen_r || fire;

    // patch bytes land in the window or ahead of the newest byte
    d = '0;
    for (int k = 0; k < WIN; k++) begin
      p = {1'b0, cfg.replace_offset} + 5'(k);
      if (fire && 4'(k) < rl_eff) begin
        if (p < {1'b0, cnt_a}) begin
          w_a[p[2:0]] = cfg.replacement[8*k +: 8];
        end else begin
          d = DW'(p) - DW'(cnt_a);
          if (d < DW'(PEND)) begin
            pv_a[d[PIW-1:0]] = cfg.replacement[8*k +: 8];
            pk_a[d[PIW-1:0]] = 1'b1;
          end
        end
      end
    end

    cnt_p = do_pop ? cnt_a - 4'd1 : cnt_a;
    fin = lastf && cnt_p == 4'd0;
    push = step && do_pop;
    push_item.data = w_a[0];
    push_item.last = fin;
    push_item.found = fin && seen_a;
  end

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    pv_nxt = pv_r;
    pk_nxt = pk_r;
    seen_nxt = seen_r;
    last_nxt = last_r;
    if (step) begin
      if (do_pop) begin
        for (int i = 0; i < WIN - 1; i++) begin
          win_nxt[i] = w_a[i + 1];
        end
        win_nxt[WIN - 1] = 8'd0;
      end else begin
        win_nxt = w_a;
      end
      pv_nxt = pv_a;
      if (push && fin) begin
        cnt_nxt = 4'd0;
        seen_nxt = 1'b0;
        last_nxt = 1'b0;
        for (int i = 0; i < PEND; i++) begin
          pk_nxt[i] = 1'b0;
        end
      end else begin
        cnt_nxt = cnt_p;
        seen_nxt = seen_a;
        last_nxt = lastf;
        pk_nxt = pk_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      seen_r <= 1'b0;
      last_r <= 1'b0;
      for (int i = 0; i < PEND; i++) begin
        pk_r[i] <= 1'b0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      seen_r <= seen_nxt;
      last_r <= last_nxt;
      pk_r <= pk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    pv_r <= pv_nxt;
  end

endmodule

/* rtl/bpfp_fifo.sv */
`timescale 1ns / 1ps
module bpfp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bpfp_pkg::bpfp_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output bpfp_pkg::bpfp_item_t q_item
);
  import bpfp_pkg::*;

  bpfp_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_pop;

  assign full = cnt_r == (QAW+1)'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_item = mem_r[rp_r];
  assign do_pop = pop && q_valid;

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

/* rtl/bpfp_back.sv */
`timescale 1ns / 1ps
module bpfp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  bpfp_pkg::bpfp_item_t q_item,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);
  import bpfp_pkg::*;

  logic       valid_r, valid_nxt;
  bpfp_item_t item_r;

  assign pop = q_valid && (!valid_r || out_tready);
  assign valid_nxt = pop || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata = item_r.data;
  assign out_tlast = item_r.last;
  assign out_tuser = item_r.found;

endmodule
